/* hdl/xte_pkg.sv */
// Shared types, constants and the byte escaping function for the XML text escape encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package xte_pkg;

  // Longest escaped run in bytes
  localparam int RUN_MAX = 6;
  localparam int IDX_W   = 3;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_S     = 8'h73;

  // One classified item: run bytes (index 0 first), index of its last byte, end-of-text flag
  typedef struct packed {
    logic [RUN_MAX-1:0][7:0] bytes;
    logic [IDX_W-1:0]        last;
    logic                    text_end;
  } desc_t;

  function automatic desc_t escape_char(input logic [7:0] c, input logic e);
    desc_t       d;
    logic [1:0]  h;
    logic [7:0]  r;
    logic [15:0] p;
    logic [3:0]  t;
    logic [7:0]  o;
    logic [7:0]  dh;
    logic [7:0]  dt;
    logic [7:0]  d_o;
    d          = '0;
    d.text_end = e;
    // decimal digits: hundreds by compare, tens by reciprocal multiply (exact below 160)
    h   = (c >= 8'd200) ? 2'd2 : ((c >= 8'd100) ? 2'd1 : 2'd0);
    r   = c - ((h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0));
    p   = 16'(r) * 16'd205;
    t   = p[14:11];
    o   = r - (8'({4'd0, t}) * 8'd10);
    dh  = CH_ZERO + {6'd0, h};
    dt  = CH_ZERO + {4'd0, t};
    d_o = CH_ZERO + o;
    if (c == CH_LT) begin
      d.bytes[0] = CH_AMP; d.bytes[1] = CH_L; d.bytes[2] = CH_T; d.bytes[3] = CH_SEMI;
      d.last = 3'd3;
    end else if (c == CH_GT) begin
      d.bytes[0] = CH_AMP; d.bytes[1] = CH_G; d.bytes[2] = CH_T; d.bytes[3] = CH_SEMI;
      d.last = 3'd3;
    end else if (c == CH_AMP) begin
      d.bytes[0] = CH_AMP; d.bytes[1] = CH_A; d.bytes[2] = CH_M; d.bytes[3] = CH_P;
      d.bytes[4] = CH_SEMI;
      d.last = 3'd4;
    end else if (c == CH_QUOT) begin
      d.bytes[0] = CH_AMP; d.bytes[1] = CH_Q; d.bytes[2] = CH_U; d.bytes[3] = CH_O;
      d.bytes[4] = CH_T; d.bytes[5] = CH_SEMI;
      d.last = 3'd5;
    end else if (c == CH_APOS) begin
      d.bytes[0] = CH_AMP; d.bytes[1] = CH_A; d.bytes[2] = CH_P; d.bytes[3] = CH_O;
      d.bytes[4] = CH_S; d.bytes[5] = CH_SEMI;
      d.last = 3'd5;
    end else if (c < CH_SPACE || c > CH_TILDE) begin
      d.bytes[0] = CH_AMP;
      d.bytes[1] = CH_HASH;
      if (c >= 8'd100) begin
        d.bytes[2] = dh; d.bytes[3] = dt; d.bytes[4] = d_o; d.bytes[5] = CH_SEMI;
        d.last = 3'd5;
      end else if (c >= 8'd10) begin
        d.bytes[2] = dt; d.bytes[3] = d_o; d.bytes[4] = CH_SEMI;
        d.last = 3'd4;
      end else begin
        d.bytes[2] = d_o; d.bytes[3] = CH_SEMI;
        d.last = 3'd3;
      end
    end else begin
      d.bytes[0] = c;
      d.last     = 3'd0;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

/* hdl/xte_front.sv */
// Front stage: takes input beats, classifies each byte into an escaped run descriptor.
// Depends on xte_pkg.
`default_nettype none

module xte_front
  import xte_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire logic [7:0] in_char,
  input  wire logic  in_end,
  output logic       push,
  input  wire logic  push_ready,
  output desc_t      push_desc
);

  logic  valid_r;
  logic  valid_nxt;
  desc_t desc_r;
  logic  take;

  assign push      = valid_r;
  assign push_desc = desc_r;
  assign in_ready  = !valid_r || push_ready;
  assign take      = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      desc_r <= escape_char(in_char, in_end);
    end
  end

endmodule

`default_nettype wire

/* hdl/xte_queue.sv */
// Short descriptor queue between the classifying front and the serialising back.
// Depends on xte_pkg.
`default_nettype none

module xte_queue
  import xte_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  output logic      wr_ready,
  input  desc_t     wr_desc,
  output logic      rd_valid,
  input  wire logic rd_en,
  output desc_t     rd_desc
);

  desc_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               do_wr;
  logic               do_rd;

  assign wr_ready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_desc  = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && wr_ready;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_desc;
    end
  end

endmodule

`default_nettype wire

/* hdl/xte_back.sv */
// Back stage: serialises one run descriptor into output beats, one byte per cycle unless the output stalls.
// Depends on xte_pkg.
`default_nettype none

module xte_back
  import xte_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  output logic       q_pop,
  input  desc_t      q_desc,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_end
);

  desc_t            cur_r;
  logic [IDX_W-1:0] idx_r;
  logic             act_r;
  logic             ov_r;
  logic [7:0]       ob_r;
  logic             ol_r;
  logic             oe_r;
  logic             emit;
  logic             at_last;

  assign emit    = act_r && (!ov_r || out_ready);
  assign at_last = (idx_r == cur_r.last);
  assign q_pop   = q_valid && (!act_r || (emit && at_last));

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_last  = ol_r;
  assign out_end   = oe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (q_pop) begin
        act_r <= 1'b1;
        idx_r <= '0;
      end else if (emit && at_last) begin
        act_r <= 1'b0;
      end else if (emit) begin
        idx_r <= idx_r + 1'b1;
      end
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_desc;
    end
    if (emit) begin
      ob_r <= cur_r.bytes[idx_r];
      ol_r <= at_last;
      oe_r <= cur_r.text_end;
    end
  end

endmodule

`default_nettype wire

/* hdl/xml_text_escape_encoder.sv */
// Top level of the XML text escape encoder: front classifier, descriptor queue, back serialiser.
// Depends on xte_pkg, xte_front, xte_queue and xte_back.
//
//  channel | dir | tdata         | tlast        | tuser
//  in_     | in  | char_in [7:0] | text_end     | -
//  out_    | out | out_char[7:0] | run_last     | text_end_out
//
// Each input byte expands to a run of 1 to 6 output beats; the back stage issues
// one beat per cycle while the output is not stalled; the first beat of a run passes the front
// register, the queue, the back stage's run register and the output register in that order.
// Reset (rst_n low, synchronous) empties front register, queue and output register.
// Either side may stall freely; the two-entry queue lets the front keep taking bytes
// while the output is held.
`default_nettype none

module xml_text_escape_encoder
  import xte_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] char_in
  input  wire logic       in_tlast,   // text_end
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_char
  output logic            out_tlast,  // run_last
  output logic            out_tuser   // [0] text_end_out
);

  logic  push;
  logic  push_ready;
  desc_t push_desc;
  logic  q_valid;
  logic  q_pop;
  desc_t q_desc;

  // classify each byte as soon as it arrives
  xte_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_char    (in_tdata),
    .in_end     (in_tlast),
    .push       (push),
    .push_ready (push_ready),
    .push_desc  (push_desc)
  );

  // decouples classification from serialisation
  xte_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_ready (push_ready),
    .wr_desc  (push_desc),
    .rd_valid (q_valid),
    .rd_en    (q_pop),
    .rd_desc  (q_desc)
  );

  // walks the run, one beat per cycle unless the output stalls, into a registered output
  xte_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_desc    (q_desc),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .out_end   (out_tuser)
  );

endmodule

`default_nettype wire

/* hdl/xte_checker.sv */
// Port-level checks for the XML text escape encoder, bound to the top level.
// Depends on xte_pkg and xml_text_escape_encoder.
`default_nettype none

module xte_checker
  import xte_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast,
  input wire logic       out_tuser
);

  logic beat_out;
  assign beat_out = out_tvalid && out_tready;

  // held beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast)
      && $stable(out_tuser))
    else $error("output beat changed while stalled");

  // a semicolon always closes its run
  a_semi: assert property (@(posedge clk) disable iff (!rst_n)
    beat_out && out_tdata == CH_SEMI |-> out_tlast)
    else $error("semicolon not last of run");

  // ampersand only ever opens an entity
  a_amp: assert property (@(posedge clk) disable iff (!rst_n)
    beat_out && out_tdata == CH_AMP |-> !out_tlast)
    else $error("bare ampersand emitted");

  // markup characters other than the ampersand never leave unescaped
  a_raw: assert property (@(posedge clk) disable iff (!rst_n)
    beat_out |-> out_tdata != CH_LT && out_tdata != CH_GT && out_tdata != CH_QUOT
      && out_tdata != CH_APOS)
    else $error("markup character passed through");

  // nothing shown straight after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind xml_text_escape_encoder xte_checker u_xte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire

/* verif/xte_escape_checker.sv */
// Checker for the XML text escape encoder: watches both stream channels, predicts each run.
// Needs nothing beyond the port signals of xml_text_escape_encoder.
`default_nettype none

module xte_escape_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic       in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tlast,
  input  wire logic       out_tvalid,
  input  wire logic       out_tready,
  input  wire logic [7:0] out_tdata,
  input  wire logic       out_tlast,
  input  wire logic       out_tuser,
  output int              fail_count,
  output int              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7e;
  localparam int         REPORT_MAX = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       text_end;
  } esc_beat_t;

  esc_beat_t escaped_beats[$];
  int        out_beats = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Expand one text byte into the beats it should produce
  function automatic void push_escaped(input logic [7:0] c, input logic e);
    string     seq;
    esc_beat_t b;
    case (c)
      8'h3c:   seq = "&lt;";
      8'h3e:   seq = "&gt;";
      8'h26:   seq = "&amp;";
      8'h22:   seq = "&quot;";
      8'h27:   seq = "&apos;";
      default: begin
        if (c < PRINT_LO || c > PRINT_HI) begin
          seq = $sformatf("&#%0d;", c);
        end else begin
          seq = " ";
          seq[0] = c;
        end
      end
    endcase
    for (int i = 0; i < seq.len(); i++) begin
      b.ch       = seq[i];
      b.run_last = (i == seq.len() - 1);
      b.text_end = e;
      escaped_beats.push_back(b);
    end
  endfunction

  always @(posedge clk) begin
    esc_beat_t want;
    if (rst_n) begin
      // input side first: a beat never leaves in the cycle its byte goes in
      if (in_tvalid && in_tready) begin
        push_escaped(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        if (escaped_beats.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("[%0t] unexpected beat %0d: char %02h last %b end %b", $realtime,
                     out_beats, out_tdata, out_tlast, out_tuser);
          end
        end else begin
          want = escaped_beats.pop_front();
          if (want.ch !== out_tdata || want.run_last !== out_tlast ||
              want.text_end !== out_tuser) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
              $display("[%0t] beat %0d mismatch: exp char %02h last %b end %b, got %02h %b %b",
                       $realtime, out_beats, want.ch, want.run_last, want.text_end,
                       out_tdata, out_tlast, out_tuser);
            end
          end
        end
        out_beats++;
      end
    end
    pending = escaped_beats.size();
  end

endmodule

`default_nettype wire

/* verif/tb_xml_text_escape_encoder.sv */
// Testbench top for xml_text_escape_encoder: drives text bytes and random output stalls.
// Depends on xte_pkg, the encoder RTL and xte_escape_checker, which predicts and checks every beat.
`default_nettype none

module tb_xml_text_escape_encoder
  import xte_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 370;
  localparam int DRAIN_CYCLES = 20;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;    // [7:0] char_in
  logic       in_tlast   = 1'b0;     // text_end
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;             // [7:0] out_char
  logic       out_tlast;             // run_last
  logic       out_tuser;             // [0] text_end_out

  int fail_count;
  int pending;

  // Sender has its own calm stretches with no gaps between bytes
  int send_calm = 0;

  always #6 clk = ~clk;

  xml_text_escape_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  xte_escape_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Byte mix: plain text, markup, control codes, delete and high bytes, anything
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      return 8'($urandom_range(32, 126));
    end else if (r < 55) begin
      case ($urandom_range(0, 4))
        0:       return CH_LT;
        1:       return CH_GT;
        2:       return CH_AMP;
        3:       return CH_QUOT;
        default: return CH_APOS;
      endcase
    end else if (r < 70) begin
      return 8'($urandom_range(0, 31));
    end else if (r < 85) begin
      return 8'($urandom_range(127, 255));
    end
    return 8'($urandom());
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  // Valid stays high into the next call when no gap is picked.
  task automatic send_byte(input logic [7:0] c, input logic e);
    int gap;
    gap = (send_calm > 0) ? 0 : pick_gap();
    if (send_calm > 0) begin
      send_calm--;
    end else if ($urandom_range(0, 59) == 0) begin
      send_calm = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'($urandom());   // idle bus carries junk
      in_tlast  <= 1'($urandom());
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= c;
    in_tlast  <= e;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the sender until every expected beat has left the block
  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  // Receiver: random stalls, with calm stretches of constant ready
  initial begin
    int calm;
    int stall;
    calm  = 0;
    stall = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (calm > 0) begin
        out_tready <= 1'b1;
        calm--;
      end else if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 39) == 0) begin
          calm = $urandom_range(50, 150);
        end else begin
          stall = pick_gap();
        end
      end
    end
  end

  // Hard stop, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [7:0] directed[$];
    int         len;
    int         sent;
    logic       e;
    // boundaries of each escape class: digit-count edges, printable edges, markup
    directed = '{8'h00, 8'h09, 8'h0a, 8'h1f, 8'h20, 8'h7e, 8'h7f, 8'h80, 8'hb3, 8'hb4,
                 8'hc7, 8'hc8, 8'hff, CH_LT, CH_GT, CH_AMP, CH_QUOT, CH_APOS, 8'h41,
                 8'h55, 8'haa};

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed bytes, end-of-text mark on every third one and on the last
    for (int i = 0; i < directed.size(); i++) begin
      send_byte(directed[i], (i % 3 == 2) || (i == directed.size() - 1));
    end
    in_tvalid <= 1'b0;
    @(negedge clk);
    wait_drained();

    // random strings, end-of-text on the last byte; a few bytes carry a stray mark
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        e = (i == len - 1);
        if ($urandom_range(0, 11) == 0) begin
          e = 1'($urandom());
        end
        send_byte(pick_char(), e);
        sent++;
      end
      // one mid-run pause with the whole pipe emptied
      if (sent >= RANDOM_ITEMS / 2 && sent - len < RANDOM_ITEMS / 2) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
        wait_drained();
      end
    end
    in_tvalid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
hdl/xte_pkg.sv
hdl/xte_front.sv
hdl/xte_queue.sv
hdl/xte_back.sv
hdl/xml_text_escape_encoder.sv
hdl/xte_checker.sv
verif/xte_escape_checker.sv
verif/tb_xml_text_escape_encoder.sv
